FILE: design/rpc_pkg.sv
// ---------------------------------------------------------------------------
// rpc_pkg: shared constants for the relation property checker
// Value width, pair width and the default pair store capacity.
// ---------------------------------------------------------------------------
package rpc_pkg;

   localparam int VALUE_W       = 32;
   localparam int PAIR_W        = 2 * VALUE_W;
   localparam int MAX_PAIRS_DEF = 256;

endpackage

FILE: design/rpc_if.sv
// ---------------------------------------------------------------------------
// rpc_if: item channels of the relation property checker
// Request channel carries one ordered pair, response channel the verdicts.
// ---------------------------------------------------------------------------
interface rpc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rpc_pkg::VALUE_W-1:0]  first_value;
   logic signed [rpc_pkg::VALUE_W-1:0]  second_value;
   logic                                carries_pair;
   logic                                last_pair;

   modport source (output valid, first_value, second_value, carries_pair, last_pair,
                   input ready);
   modport sink   (input valid, first_value, second_value, carries_pair, last_pair,
                   output ready);
endinterface

interface rpc_rsp_if;
   logic valid;
   logic ready;
   logic is_reflexive;
   logic is_symmetric;
   logic is_transitive;
   logic capacity_overflow;

   modport source (output valid, is_reflexive, is_symmetric, is_transitive,
                   capacity_overflow, input ready);
   modport sink   (input valid, is_reflexive, is_symmetric, is_transitive,
                   capacity_overflow, output ready);
endinterface

FILE: design/rpc_pair_mem.sv
// ---------------------------------------------------------------------------
// rpc_pair_mem: pair store
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module rpc_pair_mem #(
   parameter int DEPTH = rpc_pkg::MAX_PAIRS_DEF,
   parameter int IDX_W = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [rpc_pkg::PAIR_W-1:0]  wr_data,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [rpc_pkg::PAIR_W-1:0]  rd_data
);

   logic [rpc_pkg::PAIR_W-1:0] mem_ff [DEPTH];
   logic [rpc_pkg::PAIR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/relation_property_checker.sv
// Loading takes one item per cycle while idle.
// The check after the final item runs through the single read port of the pair store,
// with an inner scan per stored pair and a shortcut scan per chain candidate.
// The result sits in an output register; loading of the next relation resumes meanwhile.
// Reset (synchronous, active high) clears the sequencer, the pair count and the
// overflow flag; store contents stay undefined and need no clearing pass.
// ---------------------------------------------------------------------------
// relation_property_checker: reflexive / symmetric / transitive check
// Stores a relation as ordered pairs and scans it in nested passes when the
// final item arrives, giving one item with three verdicts and an overflow flag.
// ---------------------------------------------------------------------------
module relation_property_checker #(
   parameter int MAX_PAIRS = rpc_pkg::MAX_PAIRS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rpc_req_if.sink     req_ch,
   rpc_rsp_if.source   rsp_ch
);

   localparam int CNT_W = $clog2(MAX_PAIRS + 1);
   localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int VW    = rpc_pkg::VALUE_W;
   localparam int PW    = rpc_pkg::PAIR_W;

   // Sequencer:
   //   IDLE   - load pairs
   //   OUT_RD / OUT_CAP - fetch outer pair (a,b)
   //   J_RD / J_EVAL    - inner scan: self pairs, reverse pair, chain starts
   //   K_SCAN           - look up shortcut (a,c) for a chain (a,b),(b,c)
   //   NEXT_I           - fold per-pair findings into the verdicts
   //   DONE             - hand the verdicts to the output register
   typedef enum logic [2:0] {
      ST_IDLE, ST_OUT_RD, ST_OUT_CAP, ST_J_RD, ST_J_EVAL, ST_K_SCAN, ST_NEXT_I, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              pend_ff, pend_in;
   logic [VW-1:0]     a_ff, a_in;
   logic [VW-1:0]     b_ff, b_in;
   logic [VW-1:0]     c_ff, c_in;
   logic              aa_ff, aa_in;
   logic              bb_ff, bb_in;
   logic              ba_ff, ba_in;
   logic              refl_ff, refl_in;
   logic              sym_ff, sym_in;
   logic              trans_ff, trans_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_refl_ff, rsp_refl_in;
   logic              rsp_sym_ff, rsp_sym_in;
   logic              rsp_trans_ff, rsp_trans_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              req_fire;
   logic              rsp_free;
   logic              wr_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [PW-1:0]     rd_data;
   logic [VW-1:0]     q_left, q_right;
   logic              k_issue;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign q_left   = rd_data[PW-1:VW];
   assign q_right  = rd_data[VW-1:0];
   assign k_issue  = (k_ff != count_ff);

   // store is written only while loading, at the fill position
   assign wr_en = req_fire && req_ch.carries_pair && (count_ff < CNT_W'(MAX_PAIRS));

   // single read port shared by the outer, inner and shortcut scans
   always_comb begin
      unique case (state_ff)
         ST_J_RD:   rd_addr = j_ff[IDX_W-1:0];
         ST_K_SCAN: rd_addr = k_ff[IDX_W-1:0];
         default:   rd_addr = i_ff[IDX_W-1:0];
      endcase
   end

   rpc_pair_mem #(
      .DEPTH (MAX_PAIRS),
      .IDX_W (IDX_W)
   ) u_pair_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_ch.first_value, req_ch.second_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      ba_in        = ba_ff;
      refl_in      = refl_ff;
      sym_in       = sym_ff;
      trans_in     = trans_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_refl_in  = rsp_refl_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_trans_in = rsp_trans_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.carries_pair) begin
                  if (wr_en) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               if (req_ch.last_pair) begin
                  i_in     = '0;
                  refl_in  = 1'b1;
                  sym_in   = 1'b1;
                  trans_in = 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_OUT_RD: begin
            state_in = (i_ff == count_ff) ? ST_DONE : ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            a_in     = q_left;
            b_in     = q_right;
            aa_in    = 1'b0;
            bb_in    = 1'b0;
            ba_in    = 1'b0;
            j_in     = '0;
            state_in = ST_J_RD;
         end
         ST_J_RD: begin
            state_in = (j_ff == count_ff) ? ST_NEXT_I : ST_J_EVAL;
         end
         ST_J_EVAL: begin
            if (rd_data == {a_ff, a_ff}) aa_in = 1'b1;
            if (rd_data == {b_ff, b_ff}) bb_in = 1'b1;
            if (rd_data == {b_ff, a_ff}) ba_in = 1'b1;
            c_in = q_right;
            j_in = j_ff + CNT_W'(1);
            // chain (a,b),(b,c): look for the shortcut unless already failed
            if ((q_left == b_ff) && trans_ff) begin
               k_in     = '0;
               state_in = ST_K_SCAN;
            end else begin
               state_in = ST_J_RD;
            end
         end
         ST_K_SCAN: begin
            pend_in = k_issue;
            if (k_issue) begin
               k_in = k_ff + CNT_W'(1);
            end
            if (pend_ff && (rd_data == {a_ff, c_ff})) begin
               pend_in  = 1'b0;
               state_in = ST_J_RD;
            end else if (!k_issue && !pend_ff) begin
               trans_in = 1'b0;
               state_in = ST_J_RD;
            end
         end
         ST_NEXT_I: begin
            refl_in  = refl_ff && aa_ff && bb_ff;
            sym_in   = sym_ff && ba_ff;
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_OUT_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_refl_in  = refl_ff;
               rsp_sym_in   = sym_ff;
               rsp_trans_in = trans_ff;
               rsp_ovf_in   = overflow_ff;
               count_in     = '0;
               overflow_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      aa_ff        <= aa_in;
      bb_ff        <= bb_in;
      ba_ff        <= ba_in;
      refl_ff      <= refl_in;
      sym_ff       <= sym_in;
      trans_ff     <= trans_in;
      rsp_refl_ff  <= rsp_refl_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_trans_ff <= rsp_trans_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_ch.ready             = (state_ff == ST_IDLE);
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.is_reflexive      = rsp_refl_ff;
   assign rsp_ch.is_symmetric      = rsp_sym_ff;
   assign rsp_ch.is_transitive     = rsp_trans_ff;
   assign rsp_ch.capacity_overflow = rsp_ovf_ff;

   // fill count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAIRS))
      else $error("pair count beyond capacity");

   // a final item always starts a check
   a_last_starts_check: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.last_pair) |=> (state_ff == ST_OUT_RD))
      else $error("final item did not start the check");

   // a new result only comes out of the hand-off state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ch.ready)) |->
         $past(state_ff == ST_DONE))
      else $error("result appeared outside hand-off");

   // hand-off clears the relation for the next load
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (count_ff == '0 && !overflow_ff))
      else $error("relation not cleared after hand-off");

   // shortcut lookups run only while the transitive verdict still holds
   a_kscan_trans: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_SCAN && $past(state_ff == ST_J_EVAL)) |-> trans_ff)
      else $error("shortcut lookup after transitive failure");

endmodule
